FILE: rtl/core/uhes_pkg.sv
// shared constants and types for the url host end scanner
package uhes_pkg;

	localparam int DATA_W          = 64;
	localparam int WORD_BYTES      = 8;
	localparam int CNT_W           = 4;
	localparam int LANE_IDX_W      = 3;
	localparam int HOST_END_W      = 17;

	localparam int DEF_MAX_LEN     = 65536;
	localparam int DEF_LANES       = 8;
	localparam int DEF_QUEUE_DEPTH = 4;

	localparam logic [7:0] CH_COLON     = 8'h3A;
	localparam logic [7:0] CH_SLASH     = 8'h2F;
	localparam logic [7:0] CH_QUESTION  = 8'h3F;
	localparam logic [7:0] CH_BACKSLASH = 8'h5C;
	localparam logic [7:0] CH_OPEN_BR   = 8'h5B;
	localparam logic [7:0] CH_CLOSE_BR  = 8'h5D;

	// per-byte class as produced by the front end
	typedef struct packed {
		logic delim;
		logic colon;
		logic open_b;
		logic close_b;
	} lane_class_t;

endpackage

FILE: rtl/core/uhes_ifs.sv
// channel interfaces: input words, results, configuration writes
interface uhes_in_if
	import uhes_pkg::*;
();
	logic              valid;
	logic              ready;
	logic [DATA_W-1:0] data_word;
	logic [CNT_W-1:0]  byte_count;
	logic              last_word;

	modport source (output valid, data_word, byte_count, last_word, input ready);
	modport sink (input valid, data_word, byte_count, last_word, output ready);
endinterface

interface uhes_out_if
	import uhes_pkg::*;
();
	logic                  valid;
	logic                  ready;
	logic [HOST_END_W-1:0] host_end;
	logic                  colon_found;

	modport source (output valid, host_end, colon_found, input ready);
	modport sink (input valid, host_end, colon_found, output ready);
endinterface

interface uhes_cfg_if;
	logic valid;
	logic ready;
	logic special_mode;

	modport source (output valid, special_mode, input ready);
	modport sink (input valid, special_mode, output ready);
endinterface

FILE: rtl/core/uhes_front.sv
// front end: takes input beats, classifies each byte lane, holds the mode register
module uhes_front
	import uhes_pkg::*;
#(
	parameter int LANES = DEF_LANES,
	parameter int EW    = LANES * $bits(lane_class_t) + CNT_W + 1
) (
	input  logic            clk,
	input  logic            arst_n,
	uhes_in_if.sink         word_in,
	uhes_cfg_if.sink        cfg,
	input  logic            q_full,
	output logic            push,
	output logic [EW-1:0]   push_data
);

	logic                      mode_q;
	lane_class_t [LANES-1:0]   cls;
	logic [CNT_W-1:0]          cnt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b0;
		end else if (cfg.valid) begin
			mode_q <= cfg.special_mode;
		end
	end

	assign cfg.ready = 1'b1;

	always_comb begin
		for (int i = 0; i < LANES; i++) begin
			cls[i].colon   = word_in.data_word[8*i +: 8] == CH_COLON;
			cls[i].open_b  = word_in.data_word[8*i +: 8] == CH_OPEN_BR;
			cls[i].close_b = word_in.data_word[8*i +: 8] == CH_CLOSE_BR;
			cls[i].delim   = (word_in.data_word[8*i +: 8] == CH_COLON) ||
			                 (word_in.data_word[8*i +: 8] == CH_SLASH) ||
			                 (word_in.data_word[8*i +: 8] == CH_QUESTION) ||
			                 (mode_q && (word_in.data_word[8*i +: 8] == CH_BACKSLASH));
		end
	end

	// counts above the lane count are clipped
	assign cnt = (word_in.byte_count > CNT_W'(LANES)) ? CNT_W'(LANES) : word_in.byte_count;

	assign word_in.ready = !q_full;
	assign push          = word_in.valid && !q_full;
	assign push_data     = {word_in.last_word, cnt, cls};

endmodule

FILE: rtl/core/uhes_queue.sv
// small flop queue between front and back end
module uhes_queue
	import uhes_pkg::*;
#(
	parameter int WIDTH = 8,
	parameter int DEPTH = DEF_QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] pop_data,
	output logic             not_empty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	assign full      = count_q == CW'(DEPTH);
	assign not_empty = count_q != '0;
	assign pop_data  = mem_q[rd_ptr_q];

`ifndef SYNTH
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> count_q != CW'(DEPTH))
		else $error("queue push while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> count_q != '0)
		else $error("queue pop while empty");
`endif

endmodule

FILE: rtl/core/uhes_back.sv
// back end: bracket tracking, delimiter search, position count, result register
module uhes_back
	import uhes_pkg::*;
#(
	parameter int MAX_LEN = DEF_MAX_LEN,
	parameter int LANES   = DEF_LANES,
	parameter int EW      = LANES * $bits(lane_class_t) + CNT_W + 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          q_valid,
	input  logic [EW-1:0] q_data,
	output logic          pop,
	uhes_out_if.source    result_out
);

	localparam int PW    = $clog2(MAX_LEN + 1);
	localparam int CLS_W = LANES * $bits(lane_class_t);

	lane_class_t [LANES-1:0] cls;
	logic [CNT_W-1:0]        cnt;
	logic                    last;

	logic [PW-1:0]           pos_q;
	logic                    inb_q;
	logic                    ended_q;
	logic [PW-1:0]           loc_q;
	logic                    colon_q;

	logic                    res_valid_q;
	logic [PW-1:0]           res_end_q;
	logic                    res_colon_q;

	logic                    inb_scan;
	logic                    hit;
	logic [LANE_IDX_W-1:0]   hit_lane;
	logic                    hit_colon;
	logic [PW:0]             pos_sum;
	logic [PW:0]             hit_sum;
	logic [PW-1:0]           pos_next;
	logic [PW-1:0]           hit_pos;
	logic                    ended_new;
	logic [PW-1:0]           loc_new;
	logic                    colon_new;

	assign cls  = q_data[CLS_W-1:0];
	assign cnt  = q_data[CLS_W +: CNT_W];
	assign last = q_data[EW-1];

	// walk the lanes in order, first delimiter outside brackets wins
	always_comb begin
		inb_scan  = inb_q;
		hit       = 1'b0;
		hit_lane  = '0;
		hit_colon = 1'b0;
		for (int i = 0; i < LANES; i++) begin
			if ((CNT_W'(i) < cnt) && !ended_q && !hit) begin
				if (inb_scan) begin
					if (cls[i].close_b) begin
						inb_scan = 1'b0;
					end
				end else if (cls[i].open_b) begin
					inb_scan = 1'b1;
				end else if (cls[i].delim) begin
					hit       = 1'b1;
					hit_lane  = LANE_IDX_W'(i);
					hit_colon = cls[i].colon;
				end
			end
		end
	end

	// positions saturate at the length limit
	assign pos_sum  = {1'b0, pos_q} + (PW + 1)'(cnt);
	assign hit_sum  = {1'b0, pos_q} + (PW + 1)'(hit_lane);
	assign pos_next = (pos_sum > (PW + 1)'(MAX_LEN)) ? PW'(MAX_LEN) : pos_sum[PW-1:0];
	assign hit_pos  = (hit_sum > (PW + 1)'(MAX_LEN)) ? PW'(MAX_LEN) : hit_sum[PW-1:0];

	assign ended_new = ended_q || hit;
	assign loc_new   = ended_q ? loc_q : hit_pos;
	assign colon_new = ended_q ? colon_q : hit_colon;

	// a last beat needs room in the result register, others pass freely
	assign pop = q_valid && (!last || !res_valid_q || result_out.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= '0;
			inb_q       <= 1'b0;
			ended_q     <= 1'b0;
			loc_q       <= '0;
			colon_q     <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (pop && last) begin
				pos_q       <= '0;
				inb_q       <= 1'b0;
				ended_q     <= 1'b0;
				loc_q       <= '0;
				colon_q     <= 1'b0;
				res_valid_q <= 1'b1;
			end else begin
				if (pop) begin
					pos_q   <= pos_next;
					inb_q   <= inb_scan;
					ended_q <= ended_new;
					loc_q   <= loc_new;
					colon_q <= colon_new;
				end
				if (result_out.ready) begin
					res_valid_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && last) begin
			res_end_q   <= ended_new ? loc_new : pos_next;
			res_colon_q <= ended_new && colon_new;
		end
	end

	assign result_out.valid       = res_valid_q;
	assign result_out.host_end    = HOST_END_W'(res_end_q);
	assign result_out.colon_found = res_colon_q;

`ifndef SYNTH
	a_result_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q |-> res_end_q <= PW'(MAX_LEN))
		else $error("host end beyond length limit");
	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && last) |=> (pos_q == '0) && !inb_q && !ended_q)
		else $error("scan state not cleared after last beat");
`endif

endmodule

FILE: rtl/core/url_host_end_scanner_unit.sv
// top level of the url host end scanner
//
// word_in carries beats of up to eight host bytes, byte 0 in bits 7:0, with a
// valid byte count and a last-word mark. result_out gives one beat per string,
// on its last word: host_end (first ':' '/' '?' or, in special mode, backslash
// outside a [...] range, else the string length) and colon_found.
// cfg writes special_mode; it is always ready and applies from the next word.
// throughput: one word per cycle while the queue is not full; the lane scan in the
// back end and the classify in the front end are combinational.
// a last word is written into the queue, popped by the back end after any words
// queued ahead of it, and then loads the result register.
// the front classifies bytes and pushes into a small queue; the back end pops,
// tracks brackets and position and loads the result register.
// when result_out stalls, the back end stops only on the next last word;
// word_in keeps going until the queue fills.
// reset clears the scan state, the queue, the result valid and the mode.
module url_host_end_scanner_unit
	import uhes_pkg::*;
#(
	parameter int MAX_LEN     = DEF_MAX_LEN,
	parameter int LANES       = DEF_LANES,
	parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	uhes_in_if.sink    word_in,
	uhes_cfg_if.sink   cfg,
	uhes_out_if.source result_out
);

	// a word never carries more than eight bytes
	localparam int NL = (LANES < WORD_BYTES) ? LANES : WORD_BYTES;
	localparam int EW = NL * $bits(lane_class_t) + CNT_W + 1;

	logic          q_full;
	logic          q_push;
	logic [EW-1:0] q_push_data;
	logic          q_pop;
	logic [EW-1:0] q_pop_data;
	logic          q_valid;

	// classify stage
	uhes_front #(
		.LANES (NL),
		.EW    (EW)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.word_in   (word_in),
		.cfg       (cfg),
		.q_full    (q_full),
		.push      (q_push),
		.push_data (q_push_data)
	);

	// decouples classify from scan
	uhes_queue #(
		.WIDTH (EW),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_push_data),
		.full      (q_full),
		.pop       (q_pop),
		.pop_data  (q_pop_data),
		.not_empty (q_valid)
	);

	// scan stage and result register
	uhes_back #(
		.MAX_LEN (MAX_LEN),
		.LANES   (NL),
		.EW      (EW)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_valid    (q_valid),
		.q_data     (q_pop_data),
		.pop        (q_pop),
		.result_out (result_out)
	);

endmodule
